// File: hdl/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg - sphere vertex position shared definitions
// Constants, polynomial coefficients and control types for the vertex pipe.
// ----------------------------------------------------------------------------
package svp_pkg;

	localparam int INDEX_BITS_DEF = 10;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 16;

	localparam int SEG_W   = 11;
	localparam int RAD_W   = 15;
	localparam int OFS_W   = 16;
	localparam int FIELD_W = 10;
	localparam int TRIG_W  = 17;   // Q1.15 with room for +1.0
	localparam int POLY_W  = 31;   // Q1.30 magnitudes
	localparam int CIDX_W  = 8;

	localparam logic [CIDX_W-1:0] REG_LON_SEG = 8'd0;
	localparam logic [CIDX_W-1:0] REG_LAT_SEG = 8'd1;
	localparam logic [CIDX_W-1:0] REG_RADIUS  = 8'd2;
	localparam logic [CIDX_W-1:0] REG_OFFSET  = 8'd3;

	// Taylor terms of sin(pi/2*t), Q1.30
	localparam logic [POLY_W-1:0] K1 = 31'd1686629713;
	localparam logic [POLY_W-1:0] K3 = 31'd693598668;
	localparam logic [POLY_W-1:0] K5 = 31'd85569306;
	localparam logic [POLY_W-1:0] K7 = 31'd5026995;
	localparam logic [POLY_W-1:0] K9 = 31'd172272;

	typedef struct packed {
		logic valid;
		logic flag;
	} svp_ctrl_t;

endpackage

// File: hdl/svp_angle.sv
// ----------------------------------------------------------------------------
// svp_angle - grid index to turn-fraction angles
// Two restoring dividers, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module svp_angle import svp_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  svp_ctrl_t             ctrl_in,
	input  logic [INDEX_BITS-1:0] lon_idx,
	input  logic [INDEX_BITS-1:0] lat_idx,
	input  logic [SEG_W-1:0]      lon_div,
	input  logic [SEG_W-1:0]      lat_div,
	output svp_ctrl_t             ctrl_out,
	output logic [ANGLE_BITS-1:0] lon_angle,
	output logic [ANGLE_BITS-1:0] lat_angle
);

	localparam int DW = INDEX_BITS + ANGLE_BITS;

	svp_ctrl_t             ctrl_s [DW];
	logic [DW-1:0]         dvd_lon_s [DW];
	logic [DW-1:0]         dvd_lat_s [DW];
	logic [SEG_W-1:0]      rem_lon_s [DW];
	logic [SEG_W-1:0]      rem_lat_s [DW];
	logic [ANGLE_BITS-1:0] q_lon_s [DW];
	logic [ANGLE_BITS-1:0] q_lat_s [DW];

	logic [DW-1:0]         dvd_lon_c [DW];
	logic [DW-1:0]         dvd_lat_c [DW];
	logic [SEG_W-1:0]      rem_lon_c [DW];
	logic [SEG_W-1:0]      rem_lat_c [DW];
	logic [ANGLE_BITS-1:0] q_lon_c [DW];
	logic [ANGLE_BITS-1:0] q_lat_c [DW];

	always_comb begin
		logic [DW-1:0]         dl, dt;
		logic [SEG_W-1:0]      rl, rt;
		logic [ANGLE_BITS-1:0] ql, qt;
		logic [SEG_W:0]        tl, tt;
		for (int k = 0; k < DW; k++) begin
			if (k == 0) begin
				dl = {lon_idx, {ANGLE_BITS{1'b0}}};
				dt = {1'b0, lat_idx, {(ANGLE_BITS-1){1'b0}}};
				rl = '0;
				rt = '0;
				ql = '0;
				qt = '0;
			end else begin
				dl = dvd_lon_s[k-1];
				dt = dvd_lat_s[k-1];
				rl = rem_lon_s[k-1];
				rt = rem_lat_s[k-1];
				ql = q_lon_s[k-1];
				qt = q_lat_s[k-1];
			end
			tl = {rl, dl[DW-1]};
			tt = {rt, dt[DW-1]};
			if (tl >= {1'b0, lon_div}) begin
				rem_lon_c[k] = SEG_W'(tl - {1'b0, lon_div});
				q_lon_c[k]   = {ql[ANGLE_BITS-2:0], 1'b1};
			end else begin
				rem_lon_c[k] = tl[SEG_W-1:0];
				q_lon_c[k]   = {ql[ANGLE_BITS-2:0], 1'b0};
			end
			if (tt >= {1'b0, lat_div}) begin
				rem_lat_c[k] = SEG_W'(tt - {1'b0, lat_div});
				q_lat_c[k]   = {qt[ANGLE_BITS-2:0], 1'b1};
			end else begin
				rem_lat_c[k] = tt[SEG_W-1:0];
				q_lat_c[k]   = {qt[ANGLE_BITS-2:0], 1'b0};
			end
			dvd_lon_c[k] = {dl[DW-2:0], 1'b0};
			dvd_lat_c[k] = {dt[DW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DW; k++) ctrl_s[k] <= '0;
		end else if (en) begin
			ctrl_s[0] <= ctrl_in;
			for (int k = 1; k < DW; k++) ctrl_s[k] <= ctrl_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DW; k++) begin
				dvd_lon_s[k] <= dvd_lon_c[k];
				dvd_lat_s[k] <= dvd_lat_c[k];
				rem_lon_s[k] <= rem_lon_c[k];
				rem_lat_s[k] <= rem_lat_c[k];
				q_lon_s[k]   <= q_lon_c[k];
				q_lat_s[k]   <= q_lat_c[k];
			end
		end
	end

	assign ctrl_out  = ctrl_s[DW-1];
	assign lon_angle = q_lon_s[DW-1];
	assign lat_angle = q_lat_s[DW-1];

endmodule

// File: hdl/svp_qsin.sv
// ----------------------------------------------------------------------------
// svp_qsin - quarter-wave sine, degree 9 odd polynomial
// Six stages, one multiplier each; applies the quadrant sign at the end.
// ----------------------------------------------------------------------------
module svp_qsin import svp_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [16:0]              u,      // 0..65536 of a quarter turn
	input  logic                     neg,
	output logic signed [TRIG_W-1:0] res
);

	logic [POLY_W-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [POLY_W-1:0] t2_s1, t2_s2, t2_s3, t2_s4;
	logic [POLY_W-1:0] acc_s2, acc_s3, acc_s4, acc_s5;
	logic              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;

	logic [POLY_W-1:0]     t_in;
	logic [2*POLY_W-1:0]   sq, m2, m3, m4, m5, m6;
	logic [POLY_W:0]       rnd;
	logic [15:0]           mag;

	assign t_in = {u, 14'd0};
	assign sq   = t_in * t_in;
	assign m2   = K9 * t2_s1;
	assign m3   = acc_s2 * t2_s2;
	assign m4   = acc_s3 * t2_s3;
	assign m5   = acc_s4 * t2_s4;
	assign m6   = acc_s5 * t_s5;

	always_comb begin
		rnd = m6[2*POLY_W-1:30] + (POLY_W+1)'(1 << 14);
		if (rnd[POLY_W:15] > (POLY_W-14)'(32768)) mag = 16'd0;
		else mag = rnd[30:15];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_in;
			t2_s1  <= sq[60:30];
			neg_s1 <= neg;

			t_s2   <= t_s1;
			t2_s2  <= t2_s1;
			acc_s2 <= K7 - m2[60:30];
			neg_s2 <= neg_s1;

			t_s3   <= t_s2;
			t2_s3  <= t2_s2;
			acc_s3 <= K5 - m3[60:30];
			neg_s3 <= neg_s2;

			t_s4   <= t_s3;
			t2_s4  <= t2_s3;
			acc_s4 <= K3 - m4[60:30];
			neg_s4 <= neg_s3;

			t_s5   <= t_s4;
			acc_s5 <= K1 - m5[60:30];
			neg_s5 <= neg_s4;

			// clamp to +1.0; mag of zero with big rnd means exactly 32768
			if (rnd[POLY_W:15] >= (POLY_W-14)'(32768))
				res <= neg_s5 ? -TRIG_W'(32768) : TRIG_W'(32768);
			else
				res <= neg_s5 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

// File: hdl/sphere_vertex_position_top.sv
// ----------------------------------------------------------------------------
// sphere_vertex_position_top - UV sphere vertex position generator
// Maps a (longitude, latitude) grid point to a point on a scaled, offset sphere.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: one request per grid point, s_tdata = {lat_index, lon_index}
//    (lon in bits 9:0, lat in bits 19:10, zero padded to 24 bits).
//  m_* channel: one result per request, m_tdata = {pos_z, pos_y, pos_x},
//    m_tuser = index_out_of_range.
//  cfg_* channel: register writes, always ready; write only while idle.
//    0 lon_segments, 1 lat_segments, 2 sphere_radius, 3 height_offset.
// Throughput: one request per cycle while the output is not stalled.
// Pipeline: the restoring angle dividers, a quadrant fold stage, six
//   polynomial stages of the sine units, three product/saturate stages.
// Stall: the whole pipe holds while m_tvalid is high and m_tready low;
//   s_tready follows, so nothing is lost or repeated.
// Reset: all valid bits clear; registers return to 32, 16, 256, 0.
// ----------------------------------------------------------------------------
module sphere_vertex_position_top import svp_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // lon_index[9:0], lat_index[19:10]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
	output logic              m_tuser,   // index_out_of_range
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int SW = 40;  // saturation working width

	// configuration
	logic [SEG_W-1:0]        lon_seg_q, lat_seg_q;
	logic [RAD_W-1:0]        radius_q;
	logic signed [OFS_W-1:0] offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_seg_q <= SEG_W'(32);
			lat_seg_q <= SEG_W'(16);
			radius_q  <= RAD_W'(256);
			offset_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LON_SEG: lon_seg_q <= cfg_data[SEG_W-1:0];
				REG_LAT_SEG: lat_seg_q <= cfg_data[SEG_W-1:0];
				REG_RADIUS:  radius_q  <= cfg_data[RAD_W-1:0];
				REG_OFFSET:  offset_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// global advance: output register empty or being drained
	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// input decode
	logic [31:0]           lon_w, lat_w;
	logic [INDEX_BITS-1:0] lon_i, lat_i;
	logic [SEG_W-1:0]      lon_div, lat_div;
	svp_ctrl_t             ctrl_in;

	assign lon_w   = {22'd0, s_tdata[9:0]};
	assign lat_w   = {22'd0, s_tdata[19:10]};
	assign lon_i   = lon_w[INDEX_BITS-1:0];
	assign lat_i   = lat_w[INDEX_BITS-1:0];
	// zero count divides as one, flag catches it anyway
	assign lon_div = (lon_seg_q == '0) ? SEG_W'(1) : lon_seg_q;
	assign lat_div = (lat_seg_q == '0) ? SEG_W'(1) : lat_seg_q;
	assign ctrl_in.valid = s_tvalid;
	assign ctrl_in.flag  = (SEG_W'(lon_i) >= lon_seg_q) || (SEG_W'(lat_i) >= lat_seg_q);

	svp_ctrl_t             ctrl_a;
	logic [ANGLE_BITS-1:0] lon_a, lat_a;

	svp_angle #(
		.INDEX_BITS(INDEX_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctrl_in   (ctrl_in),
		.lon_idx   (lon_i),
		.lat_idx   (lat_i),
		.lon_div   (lon_div),
		.lat_div   (lat_div),
		.ctrl_out  (ctrl_a),
		.lon_angle (lon_a),
		.lat_angle (lat_a)
	);

	// quadrant fold: sin(a) and cos(a) = sin(a + quarter)
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS-2);

	function automatic logic [17:0] fold(input logic [ANGLE_BITS-1:0] a);
		logic [ANGLE_BITS+13:0] sh;
		logic [16:0]            uu;
		sh = {a[ANGLE_BITS-3:0], 16'd0} >> (ANGLE_BITS-2);
		uu = {1'b0, sh[15:0]};
		if (a[ANGLE_BITS-2]) uu = 17'd65536 - uu;
		return {a[ANGLE_BITS-1], uu};
	endfunction

	logic [17:0] f_sl_s1, f_cl_s1, f_st_s1, f_ct_s1;
	svp_ctrl_t   ctrl_f_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			f_sl_s1 <= fold(lon_a);
			f_cl_s1 <= fold(lon_a + QUARTER);
			f_st_s1 <= fold(lat_a);
			f_ct_s1 <= fold(lat_a + QUARTER);
		end
	end

	logic signed [TRIG_W-1:0] sl, cl, st, ct;

	svp_qsin u_sl (.clk(clk), .en(en), .u(f_sl_s1[16:0]), .neg(f_sl_s1[17]), .res(sl));
	svp_qsin u_cl (.clk(clk), .en(en), .u(f_cl_s1[16:0]), .neg(f_cl_s1[17]), .res(cl));
	svp_qsin u_st (.clk(clk), .en(en), .u(f_st_s1[16:0]), .neg(f_st_s1[17]), .res(st));
	svp_qsin u_ct (.clk(clk), .en(en), .u(f_ct_s1[16:0]), .neg(f_ct_s1[17]), .res(ct));

	// control rides alongside fold + six sine stages + two product stages
	localparam int CD = 9;
	svp_ctrl_t ctrl_d_q [CD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CD; k++) ctrl_d_q[k] <= '0;
		end else if (en) begin
			ctrl_d_q[0] <= ctrl_a;
			for (int k = 1; k < CD; k++) ctrl_d_q[k] <= ctrl_d_q[k-1];
		end
	end

	// products
	logic signed [RAD_W:0]   r_s;
	logic signed [33:0]      px_full, pz_full;
	logic signed [31:0]      px_s2, pz_s2;
	logic signed [32:0]      py_s2;
	logic signed [47:0]      mx_full, mz_full;
	logic signed [32:0]      py_full;
	logic signed [SW-1:0]    x_s3, y_s3, z_s3;

	assign r_s     = $signed({1'b0, radius_q});
	assign px_full = cl * st;
	assign pz_full = sl * st;
	assign py_full = ct * r_s;
	assign mx_full = px_s2 * r_s;
	assign mz_full = pz_s2 * r_s;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= px_full[31:0];   // |cos*sin| <= 2^30
			pz_s2 <= pz_full[31:0];
			py_s2 <= py_full;
		end
	end

	// arithmetic shift that rounds toward zero
	function automatic logic signed [SW-1:0] shrz48(input logic signed [47:0] v);
		logic signed [47:0] b;
		b = v + (v[47] ? 48'sd1073741823 : 48'sd0);
		return SW'(b >>> 30);
	endfunction

	function automatic logic signed [SW-1:0] shrz33(input logic signed [32:0] v);
		logic signed [32:0] b;
		b = v + (v[32] ? 33'sd32767 : 33'sd0);
		return SW'(b >>> 15);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= shrz48(mx_full);
			z_s3 <= shrz48(mz_full);
			y_s3 <= shrz33(py_s2) + SW'(offset_q);
		end
	end

	localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (COORD_BITS-1)) - SW'(1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	function automatic logic [15:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		c = v;
		if (c > SAT_HI) c = SAT_HI;
		if (c < SAT_LO) c = SAT_LO;
		return c[15:0];
	endfunction

	// output register
	logic [47:0] out_data_q;
	logic        out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_d_q[CD-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {sat(z_s3), sat(y_s3), sat(x_s3)};
			out_flag_q <= ctrl_d_q[CD-1].flag;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_flag_q;

endmodule
